// ===== rtl/tpt_pkg.sv =====
package tpt_pkg;

  localparam int VA_W        = 16;
  localparam int OFFSET_BITS = 8;
  localparam int PAGE_W      = VA_W - OFFSET_BITS;
  localparam int PAGE_COUNT  = 1 << PAGE_W;
  localparam int FRAME_W     = 8;
  localparam int NEXT_FREE_W = FRAME_W + 1;
  localparam int TOTAL_W     = 16;

  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [FRAME_W-1:0]     frame_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [TOTAL_W-1:0]     total_t;

endpackage

// ===== rtl/tlb_page_table_translator.sv =====
// Virtual-to-physical address translator with a FIFO TLB in front of a page
// table.
//
// Input channel: drive virtual_address and raise start for one cycle; the
// item is taken at the rising edge where start is high and busy is low.
// busy never rises, so an item may be issued in every cycle.
// Result channel: done pulses high for a single cycle once the item has passed
// the stage-1 and result registers, with physical_address, frame_number,
// tlb_hit, page_fault and the running hit_total / fault_total. The receiver
// cannot stall; each result is valid only in its done cycle and items leave
// in order. Throughput is one item per cycle. The page-table read goes
// through a registered RAM port issued in the accept cycle; the TLB compare,
// residency check and all state updates happen in the following cycle, and
// the result is registered behind that.
// Reset (synchronous, active high) empties the TLB, marks every page
// non-resident, restarts frame allocation at frame 0 and clears both totals.
// Page-table RAM and TLB contents are not cleared; the residency bits and
// the TLB fill count keep stale entries from ever being used.
module tlb_page_table_translator
  import tpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VA_W-1:0]        virtual_address,
  output logic                   done,
  output logic [VA_W-1:0]        physical_address,
  output logic [FRAME_W-1:0]     frame_number,
  output logic                   tlb_hit,
  output logic                   page_fault,
  output logic [TOTAL_W-1:0]     hit_total,
  output logic [TOTAL_W-1:0]     fault_total
);

  localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TLB_ENTRIES + 1);

  // accept stage
  logic            s1_valid;
  logic [VA_W-1:0] s1_va;

  // TLB: tags and frames in flops so every entry can be compared at once
  page_t            tlb_tags   [TLB_ENTRIES];
  frame_t           tlb_frames [TLB_ENTRIES];
  logic [FILL_W-1:0] tlb_fill;
  logic [IDX_W-1:0]  tlb_wr_ptr;

  // page table
  logic [PAGE_COUNT-1:0]  page_resident;
  frame_t                 pt_rdata;
  logic                   pt_we;
  logic [NEXT_FREE_W-1:0] next_free_frame;

  // bypass for a fault written in the same edge the next item read the RAM
  logic   byp_valid;
  page_t  byp_page;
  frame_t byp_frame;

  total_t hit_counter;
  total_t fault_counter;

  page_t   s1_page;
  offset_t s1_offset;
  logic    s1_hit;
  frame_t  s1_tlb_frame;
  logic    s1_resident;
  frame_t  s1_pt_frame;
  frame_t  s1_new_frame;
  logic    s1_fault;
  logic    s1_fill_tlb;
  frame_t  s1_frame;

  assign busy = 1'b0;

  assign s1_page   = s1_va[VA_W-1:OFFSET_BITS];
  assign s1_offset = s1_va[OFFSET_BITS-1:0];

  // Read the page table in the accept cycle so data lines up with stage 1.
  tpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGE_COUNT)
  ) u_page_frames (
    .clk   (clk),
    .we    (pt_we),
    .waddr (s1_page),
    .wdata (s1_new_frame),
    .raddr (virtual_address[VA_W-1:OFFSET_BITS]),
    .rdata (pt_rdata)
  );

  // Parallel tag compare; a page sits in the TLB at most once, so OR the hits.
  always_comb begin
    s1_hit       = 1'b0;
    s1_tlb_frame = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      if ((FILL_W'(k) < tlb_fill) && (tlb_tags[k] == s1_page)) begin
        s1_hit       = 1'b1;
        s1_tlb_frame = s1_tlb_frame | tlb_frames[k];
      end
    end
  end

  assign s1_resident  = page_resident[s1_page];
  assign s1_pt_frame  = (byp_valid && (byp_page == s1_page)) ? byp_frame : pt_rdata;
  // Once the frame pool runs dry, keep handing out the last frame.
  assign s1_new_frame = next_free_frame[FRAME_W] ? '1 : next_free_frame[FRAME_W-1:0];
  assign s1_fault     = !s1_hit && !s1_resident;
  assign s1_fill_tlb  = s1_valid && !s1_hit && s1_resident;
  assign pt_we        = s1_valid && s1_fault;

  always_comb begin
    if (s1_hit) begin
      s1_frame = s1_tlb_frame;
    end else if (s1_resident) begin
      s1_frame = s1_pt_frame;
    end else begin
      s1_frame = s1_new_frame;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    s1_va     <= virtual_address;
    byp_page  <= s1_page;
    byp_frame <= s1_new_frame;
    if (s1_fill_tlb) begin
      tlb_tags[tlb_wr_ptr]   <= s1_page;
      tlb_frames[tlb_wr_ptr] <= s1_pt_frame;
    end
    if (s1_valid) begin
      physical_address <= {s1_frame, s1_offset};
      frame_number     <= s1_frame;
      tlb_hit          <= s1_hit;
      page_fault       <= s1_fault;
      hit_total        <= (s1_hit && (hit_counter != '1)) ? hit_counter + 1'b1 : hit_counter;
      fault_total      <= (s1_fault && (fault_counter != '1)) ?
                          fault_counter + 1'b1 : fault_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      done            <= 1'b0;
      byp_valid       <= 1'b0;
      tlb_fill        <= '0;
      tlb_wr_ptr      <= '0;
      page_resident   <= '0;
      next_free_frame <= '0;
      hit_counter     <= '0;
      fault_counter   <= '0;
    end else begin
      s1_valid  <= start && !busy;
      done      <= s1_valid;
      byp_valid <= pt_we;

      // Append in round-robin order; when full the write slot is the oldest.
      if (s1_fill_tlb) begin
        tlb_wr_ptr <= (tlb_wr_ptr == IDX_W'(TLB_ENTRIES - 1)) ? '0 : tlb_wr_ptr + 1'b1;
        if (tlb_fill != FILL_W'(TLB_ENTRIES)) begin
          tlb_fill <= tlb_fill + 1'b1;
        end
      end

      if (s1_valid && s1_hit && (hit_counter != '1)) begin
        hit_counter <= hit_counter + 1'b1;
      end

      // Fault: mark the page resident, advance the free frame, count the fault.
      if (pt_we) begin
        page_resident[s1_page] <= 1'b1;
        if (!next_free_frame[FRAME_W]) begin
          next_free_frame <= next_free_frame + 1'b1;
        end
        if (fault_counter != '1) begin
          fault_counter <= fault_counter + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tpt_ram.sv =====
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tpt_checker.sv =====
module tpt_checker
  import tpt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [VA_W-1:0]    virtual_address,
  input logic               done,
  input logic [VA_W-1:0]    physical_address,
  input logic [FRAME_W-1:0] frame_number,
  input logic               tlb_hit,
  input logic               page_fault
);

  // Each taken item yields exactly one result.
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start && !busy, 2)))
    else $error("result strobe does not match accepted item");

  // The offset passes through untouched.
  a_offset_kept: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst) && !$past(rst, 2)) |->
      (physical_address[OFFSET_BITS-1:0] == $past(virtual_address[OFFSET_BITS-1:0], 2)))
    else $error("offset changed in translation");

  // The frame field and the address upper bits agree.
  a_frame_in_address: assert property (@(posedge clk) disable iff (rst)
    done |-> (physical_address[VA_W-1:OFFSET_BITS] == frame_number))
    else $error("frame number and physical address disagree");

  // A TLB hit is never a fault.
  a_hit_not_fault: assert property (@(posedge clk) disable iff (rst)
    done |-> !(tlb_hit && page_fault))
    else $error("hit and fault flagged together");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .virtual_address  (virtual_address),
  .done             (done),
  .physical_address (physical_address),
  .frame_number     (frame_number),
  .tlb_hit          (tlb_hit),
  .page_fault       (page_fault)
);

// ===== tb/tb_tlb_page_table_translator.sv =====
`timescale 1ns / 100ps

module tb_tlb_page_table_translator;
  import tpt_pkg::*;

  localparam int TLB_DEPTH   = 16;
  localparam int ITEM_COUNT  = 1900;
  localparam int TAIL_ITEMS  = 150;     // last items go out back to back
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  typedef logic [VA_W-1:0] vaddr_t;

  // One translation as the block reports it, fields in port order.
  typedef struct packed {
    vaddr_t physical_address;
    frame_t frame_number;
    logic   tlb_hit;
    logic   page_fault;
    total_t hit_total;
    total_t fault_total;
  } xlat_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  vaddr_t virtual_address = '0;
  logic   busy;
  logic   done;
  vaddr_t physical_address;
  frame_t frame_number;
  logic   tlb_hit;
  logic   page_fault;
  total_t hit_total;
  total_t fault_total;

  tlb_page_table_translator #(
    .TLB_ENTRIES(TLB_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .virtual_address(virtual_address),
    .done(done),
    .physical_address(physical_address),
    .frame_number(frame_number),
    .tlb_hit(tlb_hit),
    .page_fault(page_fault),
    .hit_total(hit_total),
    .fault_total(fault_total)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the translator state. TLB slots and page-table frames
  // are only read under the fill count and the residency bits.
  page_t                  tlb_tags [TLB_DEPTH];
  frame_t                 tlb_frames [TLB_DEPTH];
  int unsigned            tlb_fill = 0;
  int unsigned            tlb_head = 0;
  frame_t                 pt_frames [PAGE_COUNT];
  bit                     pt_resident [PAGE_COUNT];
  logic [NEXT_FREE_W-1:0] free_frame = '0;
  total_t                 hits = '0;
  total_t                 faults = '0;

  vaddr_t va_queue[$];        // addresses still to be issued
  xlat_t  pending_xlats[$];   // translations owed by the block, oldest first

  int  errors = 0;
  int  accepted_n = 0;
  int  cycle_n = 0;
  int  gap_left = 0;
  logic taken = 1'b0;         // item on the inputs was taken at the last edge

  // Translate one address and advance the shadow state.
  function automatic xlat_t translate_va(input vaddr_t va);
    page_t       pg;
    offset_t     off;
    frame_t      fr;
    logic        hit;
    logic        fault;
    int unsigned slot;
    xlat_t       r;
    pg    = va[VA_W-1:OFFSET_BITS];
    off   = va[OFFSET_BITS-1:0];
    fr    = '0;
    hit   = 1'b0;
    fault = 1'b0;
    // Search the valid TLB window, oldest entry first; first match wins.
    for (int k = 0; k < tlb_fill; k++) begin
      slot = (tlb_head + k) % TLB_DEPTH;
      if (!hit && tlb_tags[slot] == pg) begin
        fr  = tlb_frames[slot];
        hit = 1'b1;
      end
    end
    if (hit) begin
      if (hits != '1) hits++;
    end else if (pt_resident[pg]) begin
      // Resident miss: refill the TLB, dropping the oldest entry when full.
      fr = pt_frames[pg];
      if (tlb_fill >= TLB_DEPTH) begin
        tlb_head = (tlb_head + 1) % TLB_DEPTH;
        tlb_fill = TLB_DEPTH - 1;
      end
      slot = (tlb_head + tlb_fill) % TLB_DEPTH;
      tlb_tags[slot]   = pg;
      tlb_frames[slot] = fr;
      tlb_fill++;
    end else begin
      // Page fault: hand out the next free frame, stick at the top frame
      // once the pool runs dry; the TLB stays as it is.
      fault = 1'b1;
      fr = free_frame[FRAME_W] ? '1 : free_frame[FRAME_W-1:0];
      pt_frames[pg]   = fr;
      pt_resident[pg] = 1'b1;
      if (!free_frame[FRAME_W]) free_frame++;
      if (faults != '1) faults++;
    end
    r.physical_address = {fr, off};
    r.frame_number     = fr;
    r.tlb_hit          = hit;
    r.page_fault       = fault;
    r.hit_total        = hits;
    r.fault_total      = faults;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Driver: present items at the falling edge. Hold an item until it is
  // taken, then either load the next one or idle for a random burst.
  always @(negedge clk) begin : drive
    logic   nxt_start;
    vaddr_t nxt_va;
    nxt_start = start;
    nxt_va    = virtual_address;
    if (rst) begin
      nxt_start = 1'b0;
    end else if (!start || taken) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        // Idle cycle: scramble the address so the block must ignore it.
        gap_left--;
        nxt_va = vaddr_t'($urandom());
      end else if (va_queue.size() > 0) begin
        if (va_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 7);
          nxt_va   = vaddr_t'($urandom());
        end else begin
          nxt_start = 1'b1;
          nxt_va    = va_queue.pop_front();
        end
      end
    end
    start           <= nxt_start;
    virtual_address <= nxt_va;
  end

  // Monitor: at each rising edge, retire a result against the oldest
  // expectation, then predict for an item taken at this same edge.
  always @(posedge clk) begin : observe
    xlat_t want;
    xlat_t got;
    taken <= !rst && start && !busy;
    if (!rst && done) begin
      got = {physical_address, frame_number, tlb_hit, page_fault,
             hit_total, fault_total};
      if (pending_xlats.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, got pa %0h frame %0h",
                 $time, got.physical_address, got.frame_number);
      end else begin
        want = pending_xlats.pop_front();
        check_field("physical_address", want.physical_address, got.physical_address);
        check_field("frame_number", 16'(want.frame_number), 16'(got.frame_number));
        check_field("tlb_hit", 16'(want.tlb_hit), 16'(got.tlb_hit));
        check_field("page_fault", 16'(want.page_fault), 16'(got.page_fault));
        check_field("hit_total", want.hit_total, got.hit_total);
        check_field("fault_total", want.fault_total, got.fault_total);
      end
    end
    if (!rst && start && !busy) begin
      pending_xlats.push_back(translate_va(virtual_address));
      accepted_n++;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : run
    int     total_n;
    int     ws_size;
    int     ws_stride;
    int     burst;
    page_t  ws_base;
    page_t  pg;
    vaddr_t va;

    // Directed part: all-zero and all-one addresses, then for a few pages
    // a fault, a resident miss that refills the TLB, and a TLB hit.
    va_queue.push_back(16'h0000);   // fault, first frame
    va_queue.push_back(16'h00FF);   // resident miss, refill
    va_queue.push_back(16'h0080);   // hit
    va_queue.push_back(16'hFFFF);   // fault on the top page
    va_queue.push_back(16'hFF00);   // resident miss
    va_queue.push_back(16'hFF7F);   // hit
    va_queue.push_back(16'h5AA5);
    va_queue.push_back(16'hA55A);
    va_queue.push_back(16'h5A00);
    va_queue.push_back(16'hA5FF);
    va_queue.push_back(16'h5A5A);
    va_queue.push_back(16'hA5A5);
    va_queue.push_back(16'h0000);
    va_queue.push_back(16'hFFFF);
    // Fill the TLB past its depth so the oldest entries get evicted, then
    // come back to an evicted page for a resident miss.
    for (int p = 1; p <= 20; p++) begin
      va_queue.push_back({page_t'(p), offset_t'(8'h3C)});
      va_queue.push_back({page_t'(p), offset_t'(8'hC3)});
    end
    va_queue.push_back(16'h0011);   // page 0 was evicted: resident miss

    // Random part: working sets of pages with random offsets, so the
    // stream sees hits, refills and evictions; some fully random noise.
    while (va_queue.size() < ITEM_COUNT) begin
      ws_size   = $urandom_range(1, 24);
      ws_stride = $urandom_range(1, 9);
      ws_base   = page_t'($urandom());
      burst     = $urandom_range(20, 120);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0) begin
          va = vaddr_t'($urandom());
        end else begin
          pg = ws_base + page_t'(ws_stride * $urandom_range(0, ws_size - 1));
          va = {pg, offset_t'($urandom())};
        end
        va_queue.push_back(va);
      end
    end
    total_n = va_queue.size();

    // Hold reset, then drop it away from the sampling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every result to come back, then
    // keep watching to catch stray strobes.
    while (accepted_n < total_n) @(posedge clk);
    while (pending_xlats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tpt_pkg.sv
rtl/tpt_ram.sv
rtl/tlb_page_table_translator.sv
rtl/tpt_checker.sv
tb/tb_tlb_page_table_translator.sv
